/* rtl/hsl2rgb_pkg.sv */
// Shared types for the HSL to RGB converter pipeline.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

/* rtl/hsl2rgb_qp.sv */
// Saturation and lightness path: forms the ramp levels q and p and their difference.
`timescale 1ns / 1ps

module hsl2rgb_qp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  hsl2rgb_pkg::stage_en_t en,
	input  logic [FRAC_BITS:0]    saturation,
	input  logic [FRAC_BITS:0]    lightness,
	output logic [FRAC_BITS:0]    d_s4,
	output logic [FRAC_BITS:0]    p_s5,
	output logic [FRAC_BITS:0]    q_s5,
	output logic [FRAC_BITS:0]    l_s5,
	output logic                  gray_s5
);
	import hsl2rgb_pkg::*;

	localparam int W      = FRAC_BITS + 1;
	localparam int ONE_I  = 1 << FRAC_BITS;
	localparam int HALF_I = ONE_I / 2;
	localparam logic [W-1:0] ONE  = W'(ONE_I);
	localparam logic [W-1:0] HALF = W'(HALF_I);

	logic [W-1:0]   s_sat;
	logic [W-1:0]   l_sat;
	logic [W-1:0]   s_s1, l_s1, s_s2, l_s2, l_s3, l_s4;
	logic           gray_s1, gray_s2, gray_s3, gray_s4;
	logic [2*W-1:0] ls_s2;
	logic [W:0]     ls_hi;
	logic [W:0]     q_full;
	logic [W-1:0]   q_s3, q_s4;
	logic [W:0]     two_l;
	logic [W:0]     p_full;
	logic [W-1:0]   p_new;
	logic [W-1:0]   p_s4;

	assign s_sat = (saturation > ONE) ? ONE : saturation;
	assign l_sat = (lightness > ONE) ? ONE : lightness;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			s_s1    <= s_sat;
			l_s1    <= l_sat;
			gray_s1 <= (s_sat == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ls_s2   <= (2*W)'(l_s1) * (2*W)'(s_s1);
			s_s2    <= s_s1;
			l_s2    <= l_s1;
			gray_s2 <= gray_s1;
		end
	end

	assign ls_hi = ls_s2[2*W-1:FRAC_BITS];

	always_comb begin
		if (l_s2 < HALF) begin
			q_full = {1'b0, l_s2} + ls_hi;
		end else begin
			q_full = {1'b0, l_s2} + {1'b0, s_s2} - ls_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q_s3    <= (q_full > {1'b0, ONE}) ? ONE : q_full[W-1:0];
			l_s3    <= l_s2;
			gray_s3 <= gray_s2;
		end
	end

	assign two_l  = {l_s3, 1'b0};
	assign p_full = (two_l >= {1'b0, q_s3}) ? (two_l - {1'b0, q_s3}) : '0;
	assign p_new  = (p_full > {1'b0, q_s3}) ? q_s3 : p_full[W-1:0];

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q_s4    <= q_s3;
			p_s4    <= p_new;
			d_s4    <= q_s3 - p_new;
			l_s4    <= l_s3;
			gray_s4 <= gray_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q_s5    <= q_s4;
			p_s5    <= p_s4;
			l_s5    <= l_s4;
			gray_s5 <= gray_s4;
		end
	end

endmodule

/* rtl/hsl2rgb_ramp.sv */
// One color channel: evaluates the piecewise-linear hue ramp for a wrapped hue argument.
`timescale 1ns / 1ps

module hsl2rgb_ramp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  hsl2rgb_pkg::stage_en_t en,
	input  logic [FRAC_BITS-1:0]  t,
	input  logic [FRAC_BITS:0]    d_s4,
	input  logic [FRAC_BITS:0]    p_s5,
	input  logic [FRAC_BITS:0]    q_s5,
	input  logic [FRAC_BITS:0]    l_s5,
	input  logic                  gray_s5,
	output logic [FRAC_BITS:0]    chan_s6
);
	import hsl2rgb_pkg::*;

	localparam int W            = FRAC_BITS + 1;
	localparam int ONE_I        = 1 << FRAC_BITS;
	localparam int SIXTH_I      = (ONE_I + 3) / 6;
	localparam int HALF_I       = ONE_I / 2;
	localparam int TWO_THIRDS_I = (2 * ONE_I + 1) / 3;
	localparam logic [W-1:0]         ONE        = W'(ONE_I);
	localparam logic [FRAC_BITS-1:0] SIXTH      = FRAC_BITS'(SIXTH_I);
	localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(HALF_I);
	localparam logic [FRAC_BITS-1:0] TWO_THIRDS = FRAC_BITS'(TWO_THIRDS_I);

	typedef enum logic [1:0] {
		RG_RISE,
		RG_HIGH,
		RG_FALL,
		RG_LOW
	} region_t;

	logic [FRAC_BITS-1:0] t_s1;
	logic [FRAC_BITS-1:0] fall_arg;
	logic [FRAC_BITS+2:0] rise6;
	logic [FRAC_BITS+2:0] fall6;
	region_t              region_new;
	logic [W-1:0]         m_new;
	region_t              region_s2, region_s3, region_s4, region_s5;
	logic [W-1:0]         m_s2, m_s3, m_s4;
	logic [2*W-1:0]       prod_s5;
	logic [FRAC_BITS+2:0] sum;
	logic [W-1:0]         sum_sat;
	logic [W-1:0]         chan_new;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1 <= t;
		end
	end

	assign fall_arg = TWO_THIRDS - t_s1;
	assign rise6    = (FRAC_BITS+3)'(t_s1) * (FRAC_BITS+3)'(6);
	assign fall6    = (FRAC_BITS+3)'(fall_arg) * (FRAC_BITS+3)'(6);

	always_comb begin
		m_new = '0;
		priority if (t_s1 < SIXTH) begin
			region_new = RG_RISE;
			m_new      = rise6[W-1:0];
		end else if (t_s1 < HALF) begin
			region_new = RG_HIGH;
		end else if (t_s1 < TWO_THIRDS) begin
			region_new = RG_FALL;
			m_new      = fall6[W-1:0];
		end else begin
			region_new = RG_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			region_s2 <= region_new;
			m_s2      <= m_new;
		end
		if (en.s3) begin
			region_s3 <= region_s2;
			m_s3      <= m_s2;
		end
		if (en.s4) begin
			region_s4 <= region_s3;
			m_s4      <= m_s3;
		end
		if (en.s5) begin
			region_s5 <= region_s4;
			prod_s5   <= (2*W)'(d_s4) * (2*W)'(m_s4);
		end
	end

	assign sum     = (FRAC_BITS+3)'(p_s5) + (FRAC_BITS+3)'(prod_s5[2*W-1:FRAC_BITS]);
	assign sum_sat = (sum > (FRAC_BITS+3)'(ONE)) ? ONE : sum[W-1:0];

	always_comb begin
		if (gray_s5) begin
			chan_new = l_s5;
		end else begin
			unique case (region_s5)
				RG_RISE: chan_new = sum_sat;
				RG_HIGH: chan_new = q_s5;
				RG_FALL: chan_new = sum_sat;
				RG_LOW:  chan_new = p_s5;
				default: chan_new = p_s5;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			chan_s6 <= chan_new;
		end
	end

endmodule

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the pipelined HSL to RGB pixel converter.
// The converter takes one pixel per clock unless the output side stalls with the pipeline
// full, and returns its RGB result through six register stages. The six register stages
// are input saturation, the lightness-saturation product, q, p and the ramp slope, the
// per-channel slope multiply, and the output register. A stall holds only the stages that
// are full, so bubbles are squeezed out and the input stalls only when all six are occupied.
`timescale 1ns / 1ps

module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FRAC_BITS-1:0] hue,
	input  logic [FRAC_BITS:0]   saturation,
	input  logic [FRAC_BITS:0]   lightness,
	input  logic [FRAC_BITS:0]   alpha_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FRAC_BITS:0]   red,
	output logic [FRAC_BITS:0]   green,
	output logic [FRAC_BITS:0]   blue,
	output logic [FRAC_BITS:0]   alpha_out
);
	import hsl2rgb_pkg::*;

	localparam int W       = FRAC_BITS + 1;
	localparam int ONE_I   = 1 << FRAC_BITS;
	localparam int THIRD_I = (ONE_I + 1) / 3;
	localparam logic [W-1:0]         ONE       = W'(ONE_I);
	localparam logic [FRAC_BITS-1:0] THIRD     = FRAC_BITS'(THIRD_I);
	localparam logic [FRAC_BITS-1:0] NEG_THIRD = FRAC_BITS'(ONE_I - THIRD_I);

	stage_en_t            en;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [FRAC_BITS-1:0] t_red;
	logic [FRAC_BITS-1:0] t_blue;
	logic [W-1:0]         a_sat;
	logic [W-1:0]         a_s1, a_s2, a_s3, a_s4, a_s5, a_s6;
	logic [W-1:0]         d_s4, p_s5, q_s5, l_s5;
	logic                 gray_s5;

	assign en.s6 = !v_s6 || !out_stall;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_stall  = !en.s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	assign a_sat = (alpha_in > ONE) ? ONE : alpha_in;

	always_ff @(posedge clk) begin
		if (en.s1) a_s1 <= a_sat;
		if (en.s2) a_s2 <= a_s1;
		if (en.s3) a_s3 <= a_s2;
		if (en.s4) a_s4 <= a_s3;
		if (en.s5) a_s5 <= a_s4;
		if (en.s6) a_s6 <= a_s5;
	end

	assign alpha_out = a_s6;

	assign t_red  = hue + THIRD;
	assign t_blue = hue + NEG_THIRD;

	hsl2rgb_qp #(
		.FRAC_BITS (FRAC_BITS)
	) u_qp (
		.clk        (clk),
		.en         (en),
		.saturation (saturation),
		.lightness  (lightness),
		.d_s4       (d_s4),
		.p_s5       (p_s5),
		.q_s5       (q_s5),
		.l_s5       (l_s5),
		.gray_s5    (gray_s5)
	);

	hsl2rgb_ramp #(
		.FRAC_BITS (FRAC_BITS)
	) u_ramp_red (
		.clk     (clk),
		.en      (en),
		.t       (t_red),
		.d_s4    (d_s4),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.l_s5    (l_s5),
		.gray_s5 (gray_s5),
		.chan_s6 (red)
	);

	hsl2rgb_ramp #(
		.FRAC_BITS (FRAC_BITS)
	) u_ramp_green (
		.clk     (clk),
		.en      (en),
		.t       (hue),
		.d_s4    (d_s4),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.l_s5    (l_s5),
		.gray_s5 (gray_s5),
		.chan_s6 (green)
	);

	hsl2rgb_ramp #(
		.FRAC_BITS (FRAC_BITS)
	) u_ramp_blue (
		.clk     (clk),
		.en      (en),
		.t       (t_blue),
		.d_s4    (d_s4),
		.p_s5    (p_s5),
		.q_s5    (q_s5),
		.l_s5    (l_s5),
		.gray_s5 (gray_s5),
		.chan_s6 (blue)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled while a pipeline stage is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted request did not reach the first stage");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE) && (alpha_out <= ONE))
		else $error("result channel above full scale");
`endif

endmodule

/* dv/hsl_to_rgb_converter_checker.sv */
// Checker that predicts and compares every converted pixel of the HSL to RGB converter.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [FRAC_BITS-1:0] hue,
	input  logic [FRAC_BITS:0]   saturation,
	input  logic [FRAC_BITS:0]   lightness,
	input  logic [FRAC_BITS:0]   alpha_in,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [FRAC_BITS:0]   red,
	input  logic [FRAC_BITS:0]   green,
	input  logic [FRAC_BITS:0]   blue,
	input  logic [FRAC_BITS:0]   alpha_out,
	output int                   mismatch_count,
	output int                   pixels_checked,
	output int                   pixels_pending
);

	localparam longint unsigned ONE        = 64'd1 << FRAC_BITS;
	localparam longint unsigned HUE_MASK   = ONE - 1;
	localparam longint unsigned THIRD      = (ONE + 1) / 3;
	localparam longint unsigned SIXTH      = (ONE + 3) / 6;
	localparam longint unsigned HALF       = ONE / 2;
	localparam longint unsigned TWO_THIRDS = (2 * ONE + 1) / 3;

	typedef struct packed {
		logic [FRAC_BITS:0] red;
		logic [FRAC_BITS:0] green;
		logic [FRAC_BITS:0] blue;
		logic [FRAC_BITS:0] alpha;
	} rgba_pixel_t;

	rgba_pixel_t rgba_expected_q[$];
	rgba_pixel_t want_pixel;
	rgba_pixel_t got_pixel;

	function automatic longint unsigned clamp_one(input longint unsigned v);
		return (v > ONE) ? ONE : v;
	endfunction

	function automatic longint unsigned hue_ramp(input longint unsigned p,
		input longint unsigned q, input longint unsigned t);
		longint unsigned d;
		longint unsigned r;
		d = q - p;
		if (t < SIXTH) begin
			r = p + ((d * 6 * t) >> FRAC_BITS);
		end else if (t < HALF) begin
			r = q;
		end else if (t < TWO_THIRDS) begin
			r = p + ((d * 6 * (TWO_THIRDS - t)) >> FRAC_BITS);
		end else begin
			r = p;
		end
		return clamp_one(r);
	endfunction

	function automatic rgba_pixel_t hsl_to_rgba(input logic [FRAC_BITS-1:0] h_in,
		input logic [FRAC_BITS:0] s_in, input logic [FRAC_BITS:0] l_in,
		input logic [FRAC_BITS:0] a_in);
		longint unsigned h;
		longint unsigned s;
		longint unsigned l;
		longint unsigned q;
		longint unsigned p;
		rgba_pixel_t px;
		h = longint'(h_in) & HUE_MASK;
		s = clamp_one(longint'(s_in));
		l = clamp_one(longint'(l_in));
		px.alpha = (FRAC_BITS+1)'(clamp_one(longint'(a_in)));
		if (s == 0) begin
			px.red   = (FRAC_BITS+1)'(l);
			px.green = (FRAC_BITS+1)'(l);
			px.blue  = (FRAC_BITS+1)'(l);
		end else begin
			if (l < HALF) begin
				q = (l * (ONE + s)) >> FRAC_BITS;
			end else begin
				q = l + s - ((l * s) >> FRAC_BITS);
			end
			if (q > ONE) begin
				q = ONE;
			end
			p = (2 * l >= q) ? 2 * l - q : 0;
			if (p > q) begin
				p = q;
			end
			px.red   = (FRAC_BITS+1)'(hue_ramp(p, q, (h + THIRD) & HUE_MASK));
			px.green = (FRAC_BITS+1)'(hue_ramp(p, q, h));
			px.blue  = (FRAC_BITS+1)'(hue_ramp(p, q, (h + ONE - THIRD) & HUE_MASK));
		end
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgba_expected_q.delete();
			mismatch_count <= 0;
			pixels_checked <= 0;
			pixels_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_pixel = '{red, green, blue, alpha_out};
				if (rgba_expected_q.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected pixel r=%0d g=%0d b=%0d a=%0d at %0t",
							red, green, blue, alpha_out, $realtime);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					want_pixel = rgba_expected_q.pop_front();
					if (got_pixel != want_pixel) begin
						if (mismatch_count < 10) begin
							$display("pixel %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
								pixels_checked, want_pixel.red, want_pixel.green,
								want_pixel.blue, want_pixel.alpha, red, green, blue,
								alpha_out);
						end
						mismatch_count <= mismatch_count + 1;
					end
					pixels_checked <= pixels_checked + 1;
				end
			end
			if (in_valid && !in_stall) begin
				rgba_expected_q.push_back(hsl_to_rgba(hue, saturation, lightness, alpha_in));
			end
			pixels_pending <= rgba_expected_q.size();
		end
	end

endmodule

/* dv/hsl_to_rgb_converter_test.sv */
// Testbench top for the HSL to RGB converter: stimulus, stalls, timeout and verdict.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

	localparam int FRAC_BITS  = 16;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int THIRD      = (ONE + 1) / 3;
	localparam int SIXTH      = (ONE + 3) / 6;
	localparam int HALF       = ONE / 2;
	localparam int TWO_THIRDS = (2 * ONE + 1) / 3;
	localparam int VAL_MAX    = 2 * ONE - 1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD  = 200;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [FRAC_BITS-1:0] hue = '0;
	logic [FRAC_BITS:0]   saturation = '0;
	logic [FRAC_BITS:0]   lightness = '0;
	logic [FRAC_BITS:0]   alpha_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FRAC_BITS:0]   red;
	logic [FRAC_BITS:0]   green;
	logic [FRAC_BITS:0]   blue;
	logic [FRAC_BITS:0]   alpha_out;

	int mismatch_count;
	int pixels_checked;
	int pixels_pending;
	int requests_sent = 0;
	int in_gap_max = 0;
	int out_gap_max = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int cycle_count = 0;

	hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.hue(hue), .saturation(saturation), .lightness(lightness), .alpha_in(alpha_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .alpha_out(alpha_out)
	);

	hsl_to_rgb_converter_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.hue(hue), .saturation(saturation), .lightness(lightness), .alpha_in(alpha_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .alpha_out(alpha_out),
		.mismatch_count(mismatch_count), .pixels_checked(pixels_checked),
		.pixels_pending(pixels_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d pixels pending", cycle_count,
				pixels_pending);
			$display("hsl_to_rgb_converter verification failed");
			$finish;
		end
	end

	// The output side stalls a random number of cycles before each pixel, or for a
	// long stretch whenever the stimulus asks for one.
	initial begin
		int n;
		forever begin
			if (hold_requests != holds_done) begin
				n = LONG_HOLD;
				holds_done = holds_done + 1;
			end else begin
				n = $urandom_range(0, out_gap_max);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pixel(input int h, input int s, input int l, input int a);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hue        <= h[FRAC_BITS-1:0];
		saturation <= s[FRAC_BITS:0];
		lightness  <= l[FRAC_BITS:0];
		alpha_in   <= a[FRAC_BITS:0];
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent = requests_sent + 1;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
	endtask

	function automatic int pick_level(input int mid);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 2) begin
			return 0;
		end else if (sel < 4) begin
			return ONE;
		end else if (sel < 5) begin
			return mid;
		end else if (sel < 7) begin
			return $urandom_range(ONE + 1, VAL_MAX);
		end
		return $urandom_range(1, ONE - 1);
	endfunction

	function automatic int pick_hue();
		int edges[6];
		edges = '{0, SIXTH, HALF, TWO_THIRDS, THIRD, ONE - THIRD};
		if ($urandom_range(0, 9) < 3) begin
			return (edges[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2) & (ONE - 1);
		end
		return $urandom_range(0, ONE - 1);
	endfunction

	initial begin
		int chunk;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_gap_max <= 2;
		out_gap_max <= 2;
		send_pixel(0, 0, 0, 0);
		send_pixel(ONE - 1, 0, ONE, ONE);
		send_pixel(12345, 0, VAL_MAX, VAL_MAX);
		send_pixel(0, ONE, HALF, ONE);
		send_pixel(THIRD, ONE, HALF, 0);
		send_pixel(ONE - THIRD, ONE, HALF, HALF);
		send_pixel(SIXTH - 1, ONE, HALF - 1, ONE);
		send_pixel(SIXTH, ONE, HALF, ONE);
		send_pixel(HALF - 1, VAL_MAX, HALF, ONE + 1);
		send_pixel(HALF, ONE, ONE - 1, ONE);
		send_pixel(TWO_THIRDS - 1, ONE, ONE, ONE);
		send_pixel(TWO_THIRDS, ONE / 3, 1, ONE);
		send_pixel(ONE - 1, 1, ONE - 1, ONE);
		send_pixel(ONE - 1, ONE + 1, ONE + 1, 1);
		send_pixel(21000, 40000, 20000, 30000);
		send_pixel(50000, 65535, 32767, 65535);
		send_pixel(5000, VAL_MAX, 1, VAL_MAX);
		send_pixel(HALF + 1, ONE - 1, VAL_MAX, 0);
		send_pixel(1, 1, HALF, ONE);
		send_pixel(TWO_THIRDS + 1, 43690, 65535, 21845);
		wait_drained();

		for (chunk = 0; chunk < 13; chunk++) begin
			case (chunk % 4)
				0: begin in_gap_max <= 0; out_gap_max <= 0; end
				1: begin in_gap_max <= 5; out_gap_max <= 5; end
				2: begin in_gap_max <= 5; out_gap_max <= 0; end
				default: begin in_gap_max <= 0; out_gap_max <= 5; end
			endcase
			if (chunk == 4) begin
				hold_requests <= hold_requests + 1;
			end
			if (chunk == 9) begin
				wait_drained();
			end
			repeat (100) begin
				send_pixel(pick_hue(), pick_level(HALF), pick_level(HALF),
					pick_level(HALF));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests and checked %0d pixels across gray, saturated, over-range,",
			requests_sent, pixels_checked);
		$display("hue-boundary and random pixels under idle gaps, stalls and a full-pipe hold.");
		if (mismatch_count == 0 && pixels_pending == 0) begin
			$display("hsl_to_rgb_converter verification clean");
		end else begin
			$display("hsl_to_rgb_converter verification failed");
		end
		$finish;
	end

endmodule
